FILE: hdl/ppe_pkg.sv
`timescale 1ns / 1ps

package ppe_pkg;

	localparam int POOL_SIZE = 1024;
	localparam int AW        = $clog2(POOL_SIZE);
	localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

	// life values are positive 31-bit Q15.16, life fraction is Q0.16
	localparam int LIFE_W = 31;
	localparam int FRAC_W = 16;

	localparam logic [18:0]        TWO_PI_Q16 = 19'd411775;
	localparam logic [9:0]         SPIN_Q16   = 10'd655;
	localparam logic signed [17:0] HALF_Q16   = 18'sd32768;
	localparam logic [16:0]        ONE_Q16    = 17'd65536;

	typedef enum logic [1:0] {
		ACT_EMIT   = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_RENDER = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_COLOR_BEGIN = 3'd0,
		REG_COLOR_END   = 3'd1,
		REG_SIZE_BEGIN  = 3'd2,
		REG_SIZE_END    = 3'd3,
		REG_SIZE_VAR    = 3'd4,
		REG_VEL_VAR_X   = 3'd5,
		REG_VEL_VAR_Y   = 3'd6,
		REG_LIFE_TIME   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic               active;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic        [31:0] rot;
		logic signed [31:0] life_left;
		logic signed [31:0] life_total;
		logic signed [31:0] size_b;
		logic signed [31:0] size_e;
		logic        [31:0] col_b;
		logic        [31:0] col_e;
	} ppe_entry_t;

	localparam int ENTRY_W = $bits(ppe_entry_t);

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sh07FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end else if (v < -36'sh080000000) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

FILE: hdl/ppe_ram.sv
`timescale 1ns / 1ps

module ppe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/ppe_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
// quot = floor(dividend * 2^FRAC_W / divisor), requires dividend < divisor
module ppe_div import ppe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LIFE_W-1:0] dividend,
	input  logic [LIFE_W-1:0] divisor,
	output logic              done,
	output logic [FRAC_W-1:0] quot
);

	localparam int CNT_W = $clog2(FRAC_W + 1);

	logic [LIFE_W-1:0] rem_q;
	logic [FRAC_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [LIFE_W:0]   shifted;
	logic [LIFE_W:0]   diff;
	logic              ge;

	always_comb begin
		shifted = {rem_q, 1'b0};
		ge      = shifted >= {1'b0, divisor};
		diff    = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(FRAC_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[LIFE_W-1:0] : shifted[LIFE_W-1:0];
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: hdl/particle_pool_engine.sv
`timescale 1ns / 1ps

// From the accepting cycle until s_tready is high again: emit writes the new entry; tick
// walks the pool through the entry RAM; render reads the entry, runs the bit-serial divider
// when the life fraction needs it, then multiplies; the word is on m_tvalid as s_tready rises.
// Throughput: one word at a time; the next word is taken when the current one is done,
// even while a render result still waits (a second render then holds in its output cycle).
// Reset: arst_n clears control state, loads register defaults, then a clearing pass
// writes every RAM entry inactive with s_tready low.
module particle_pool_engine import ppe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// origin_x, origin_y, vel_x, vel_y, time_step, slot, rand_angle,
	// rand_vx, rand_vy, rand_size; zero pad
	input  logic [223:0] s_tdata,
	// action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, angle, quad_size, color
	output logic [159:0] m_tdata,
	// alive
	output logic [0:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EMIT,
		ST_TICK,
		ST_REN_RD,
		ST_REN_DIV,
		ST_REN_MUL,
		ST_REN_OUT
	} state_t;

	// input fields
	logic signed [31:0] in_origin_x, in_origin_y, in_vel_x, in_vel_y;
	logic [15:0]        in_time_step, in_rand_angle, in_rand_vx, in_rand_vy, in_rand_size;
	logic [9:0]         in_slot;
	action_t            in_action;
	logic               accept;

	assign in_origin_x   = s_tdata[31:0];
	assign in_origin_y   = s_tdata[63:32];
	assign in_vel_x      = s_tdata[95:64];
	assign in_vel_y      = s_tdata[127:96];
	assign in_time_step  = s_tdata[143:128];
	assign in_slot       = s_tdata[153:144];
	assign in_rand_angle = s_tdata[169:154];
	assign in_rand_vx    = s_tdata[185:170];
	assign in_rand_vy    = s_tdata[201:186];
	assign in_rand_size  = s_tdata[217:202];
	assign in_action     = action_t'(s_tuser);

	// config registers
	logic [31:0]       color_begin_q, color_end_q;
	logic [LIFE_W-1:0] size_begin_q, size_end_q, size_var_q;
	logic [LIFE_W-1:0] vel_var_x_q, vel_var_y_q, life_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_begin_q <= 32'hFFFF_FFFF;
			color_end_q   <= '0;
			size_begin_q  <= 31'd65536;
			size_end_q    <= '0;
			size_var_q    <= '0;
			vel_var_x_q   <= '0;
			vel_var_y_q   <= '0;
			life_time_q   <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_COLOR_BEGIN: color_begin_q <= cfg_data;
				REG_COLOR_END:   color_end_q   <= cfg_data;
				REG_SIZE_BEGIN:  size_begin_q  <= cfg_data[LIFE_W-1:0];
				REG_SIZE_END:    size_end_q    <= cfg_data[LIFE_W-1:0];
				REG_SIZE_VAR:    size_var_q    <= cfg_data[LIFE_W-1:0];
				REG_VEL_VAR_X:   vel_var_x_q   <= cfg_data[LIFE_W-1:0];
				REG_VEL_VAR_Y:   vel_var_y_q   <= cfg_data[LIFE_W-1:0];
				REG_LIFE_TIME:   life_time_q   <= cfg_data[LIFE_W-1:0];
				default: ;
			endcase
		end
	end

	state_t state_q;

	// control registers
	logic [AW-1:0] clr_q;
	logic [AW-1:0] next_slot_q;
	logic [AW-1:0] tick_addr_q;
	logic          tick_rd_done_q;
	logic          tick_v_s1, tick_v_s2;
	logic          m_tvalid_q;

	// payload registers
	logic [AW-1:0]      tick_addr_s1, tick_addr_s2;
	ppe_entry_t         tick_ent_s2;
	logic signed [48:0] prod_x_s2, prod_y_s2;
	logic [15:0]        step_q;
	logic [31:0]        spin_q;
	logic signed [31:0] org_x_q, org_y_q, vbase_x_q, vbase_y_q;
	logic [31:0]        rot0_q;
	logic signed [33:0] spread_x_q, spread_y_q, spread_s_q;
	logic               slot_ok_q;
	ppe_entry_t         ren_e_q;
	logic               ren_alive_q;
	logic [16:0]        frac_q;
	logic signed [50:0] size_prod_q;
	logic signed [26:0] col_prod_q [4];
	logic [159:0]       m_tdata_q;
	logic               m_alive_q;

	// entry RAM ports
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	ppe_entry_t         ram_wdata, ram_rdata;

	// divider
	logic              div_start, div_done;
	logic [FRAC_W-1:0] div_quot;

	ppe_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(POOL_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ppe_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(ram_rdata.life_left[LIFE_W-1:0]),
		.divisor (ram_rdata.life_total[LIFE_W-1:0]),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// render decision on the word just read
	logic ren_live, ren_zero, ren_full;
	assign ren_live = slot_ok_q && ram_rdata.active;
	assign ren_zero = (ram_rdata.life_left <= 0);
	assign ren_full = (ram_rdata.life_left >= ram_rdata.life_total);
	assign div_start = (state_q == ST_REN_RD) && ren_live && !ren_zero && !ren_full;

	// emitted entry
	ppe_entry_t emit_ent;
	always_comb begin
		emit_ent            = '0;
		emit_ent.active     = 1'b1;
		emit_ent.pos_x      = org_x_q;
		emit_ent.pos_y      = org_y_q;
		emit_ent.rot        = rot0_q;
		emit_ent.vel_x      = sat32(36'(vbase_x_q) + 36'(spread_x_q));
		emit_ent.vel_y      = sat32(36'(vbase_y_q) + 36'(spread_y_q));
		emit_ent.col_b      = color_begin_q;
		emit_ent.col_e      = color_end_q;
		emit_ent.life_total = {1'b0, life_time_q};
		emit_ent.life_left  = {1'b0, life_time_q};
		emit_ent.size_b     = sat32(36'(signed'({1'b0, size_begin_q})) + 36'(spread_s_q));
		emit_ent.size_e     = {1'b0, size_end_q};
	end

	// ticked entry
	ppe_entry_t         tick_ent;
	logic signed [32:0] dpos_x, dpos_y;
	always_comb begin
		dpos_x   = prod_x_s2[48:16];
		dpos_y   = prod_y_s2[48:16];
		tick_ent = tick_ent_s2;
		if (tick_ent_s2.active) begin
			if (tick_ent_s2.life_left <= 0) begin
				tick_ent.active = 1'b0;
			end else begin
				tick_ent.life_left = sat32(36'(tick_ent_s2.life_left) -
					36'(signed'({1'b0, step_q})));
				tick_ent.pos_x = sat32(36'(tick_ent_s2.pos_x) + 36'(dpos_x));
				tick_ent.pos_y = sat32(36'(tick_ent_s2.pos_y) + 36'(dpos_y));
				tick_ent.rot   = tick_ent_s2.rot + spin_q;
			end
		end
	end

	// RAM port steering: one writer per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tick_addr_s2;
		ram_wdata = tick_ent;
		ram_re    = 1'b0;
		ram_raddr = tick_addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_EMIT: begin
				ram_we    = 1'b1;
				ram_waddr = next_slot_q;
				ram_wdata = emit_ent;
			end
			ST_TICK: begin
				ram_we = tick_v_s2;
				ram_re = !tick_rd_done_q;
			end
			ST_IDLE: begin
				ram_re    = accept && (in_action == ACT_RENDER);
				ram_raddr = AW'(in_slot);
			end
			default: ;
		endcase
	end

	// render output word
	logic [159:0]       out_word;
	logic signed [34:0] dsize;
	logic [31:0]        out_color;
	always_comb begin
		dsize     = size_prod_q[50:16];
		out_color = '0;
		for (int c = 0; c < 4; c++) begin
			out_color[8*c +: 8] = ren_e_q.col_e[8*c +: 8] + col_prod_q[c][23:16];
		end
		if (ren_alive_q) begin
			out_word = {out_color,
				sat32(36'(ren_e_q.size_e) + 36'(dsize)),
				ren_e_q.rot, ren_e_q.pos_y, ren_e_q.pos_x};
		end else begin
			out_word = '0;
		end
	end

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// state machine and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			next_slot_q    <= LAST_SLOT;
			tick_addr_q    <= '0;
			tick_rd_done_q <= 1'b0;
			tick_v_s1      <= 1'b0;
			tick_v_s2      <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			tick_v_s1 <= (state_q == ST_TICK) && !tick_rd_done_q;
			tick_v_s2 <= tick_v_s1;
			// a new render word fills an empty output or replaces the one taken in this cycle
			if (state_q == ST_REN_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (in_action)
							ACT_EMIT: state_q <= ST_EMIT;
							ACT_TICK: begin
								state_q        <= ST_TICK;
								tick_addr_q    <= '0;
								tick_rd_done_q <= 1'b0;
							end
							ACT_RENDER: state_q <= ST_REN_RD;
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					next_slot_q <= (next_slot_q == '0) ? LAST_SLOT : next_slot_q - 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_TICK: begin
					if (!tick_rd_done_q) begin
						tick_addr_q <= tick_addr_q + 1'b1;
						if (tick_addr_q == LAST_SLOT) begin
							tick_rd_done_q <= 1'b1;
						end
					end else if (!tick_v_s1 && !tick_v_s2) begin
						state_q <= ST_IDLE;
					end
				end
				ST_REN_RD: begin
					state_q <= div_start ? ST_REN_DIV : ST_REN_MUL;
				end
				ST_REN_DIV: begin
					if (div_done) begin
						state_q <= ST_REN_MUL;
					end
				end
				ST_REN_MUL: state_q <= ST_REN_OUT;
				ST_REN_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// tick pipe: s1 is the RAM read, s2 holds products
		tick_addr_s1 <= tick_addr_q;
		tick_addr_s2 <= tick_addr_s1;
		tick_ent_s2  <= ram_rdata;
		prod_x_s2    <= ram_rdata.vel_x * signed'({1'b0, step_q});
		prod_y_s2    <= ram_rdata.vel_y * signed'({1'b0, step_q});

		if (accept) begin
			step_q     <= in_time_step;
			spin_q     <= 32'(26'(in_time_step * SPIN_Q16) >> 16);
			org_x_q    <= in_origin_x;
			org_y_q    <= in_origin_y;
			vbase_x_q  <= in_vel_x;
			vbase_y_q  <= in_vel_y;
			rot0_q     <= 32'(35'(in_rand_angle * TWO_PI_Q16) >> 16);
			// full 48-bit product before the floor shift
			spread_x_q <= 34'(48'(signed'({1'b0, vel_var_x_q}) *
				(signed'({2'b0, in_rand_vx}) - HALF_Q16)) >>> 16);
			spread_y_q <= 34'(48'(signed'({1'b0, vel_var_y_q}) *
				(signed'({2'b0, in_rand_vy}) - HALF_Q16)) >>> 16);
			spread_s_q <= 34'(48'(signed'({1'b0, size_var_q}) *
				(signed'({2'b0, in_rand_size}) - HALF_Q16)) >>> 16);
			slot_ok_q  <= (32'(in_slot) < 32'(POOL_SIZE));
		end

		if (state_q == ST_REN_RD) begin
			ren_e_q     <= ram_rdata;
			ren_alive_q <= ren_live;
			frac_q      <= ren_zero ? 17'd0 : ONE_Q16;
		end
		if (state_q == ST_REN_DIV && div_done) begin
			frac_q <= {1'b0, div_quot};
		end
		if (state_q == ST_REN_MUL) begin
			size_prod_q <= (33'(ren_e_q.size_b) - 33'(ren_e_q.size_e)) *
				signed'({1'b0, frac_q});
			for (int c = 0; c < 4; c++) begin
				col_prod_q[c] <= (signed'({1'b0, ren_e_q.col_b[8*c +: 8]}) -
					signed'({1'b0, ren_e_q.col_e[8*c +: 8]})) * signed'({1'b0, frac_q});
			end
		end
		if (state_q == ST_REN_OUT && out_free) begin
			m_tdata_q <= out_word;
			m_alive_q <= ren_alive_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_alive_q;

endmodule

FILE: sim/particle_pool_engine_tb.sv
`timescale 1ns / 1ps

module particle_pool_engine_tb;
	import ppe_pkg::*;

	// render result as seen on the master side
	typedef struct packed {
		logic        alive;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] angle;
		logic [31:0] quad_size;
		logic [31:0] color;
	} render_t;

	localparam int WATCHDOG_LIMIT = 40000;
	// a tick walks the whole pool with no result; let it finish before a config write
	localparam int DRAIN_CYCLES   = POOL_SIZE + 80;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [223:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [31:0]  cfg_data;

	particle_pool_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	// emitter settings as the block should hold them
	logic [31:0] emit_color_b, emit_color_e;
	logic [30:0] emit_size_b, emit_size_e, emit_size_var;
	logic [30:0] emit_vvar_x, emit_vvar_y, emit_life;

	// shadow copy of the pool
	logic        live     [POOL_SIZE];
	int          px       [POOL_SIZE];
	int          py       [POOL_SIZE];
	int          vx       [POOL_SIZE];
	int          vy       [POOL_SIZE];
	logic [31:0] spin_acc [POOL_SIZE];
	int          life_left[POOL_SIZE];
	int          life_all [POOL_SIZE];
	int          sz_b     [POOL_SIZE];
	int          sz_e     [POOL_SIZE];
	logic [31:0] col_b    [POOL_SIZE];
	logic [31:0] col_e    [POOL_SIZE];
	logic [AW-1:0] emit_ptr;

	render_t pending_renders[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int words_sent;
	int renders_checked;
	int ticks_sent;
	int emits_sent;
	int retired_seen;
	int idle_cycles;

	// ---------------------------------------------------------------
	// clock and receiver side
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ---------------------------------------------------------------
	// predictor helpers
	// ---------------------------------------------------------------
	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return int'(v);
	endfunction

	// centered random spread: var * (r - 0.5), floored
	function automatic longint jitter(logic [30:0] spread_q, logic [15:0] r);
		return (longint'(spread_q) * (longint'(r) - 64'sd32768)) >>> 16;
	endfunction

	task automatic apply_emit(logic [31:0] ox, logic [31:0] oy, logic [31:0] bvx,
			logic [31:0] bvy, logic [15:0] ra, logic [15:0] rvx, logic [15:0] rvy,
			logic [15:0] rsz);
		logic [AW-1:0] s;
		longint rot;
		s = emit_ptr;
		rot = (longint'(ra) * 411775) >> 16;
		live[s]      = 1'b1;
		px[s]        = int'(ox);
		py[s]        = int'(oy);
		spin_acc[s]  = rot[31:0];
		vx[s]        = clamp32(longint'(int'(bvx)) + jitter(emit_vvar_x, rvx));
		vy[s]        = clamp32(longint'(int'(bvy)) + jitter(emit_vvar_y, rvy));
		col_b[s]     = emit_color_b;
		col_e[s]     = emit_color_e;
		life_all[s]  = int'({1'b0, emit_life});
		life_left[s] = int'({1'b0, emit_life});
		sz_b[s]      = clamp32(longint'(emit_size_b) + jitter(emit_size_var, rsz));
		sz_e[s]      = int'({1'b0, emit_size_e});
		emit_ptr     = s - 1'b1; // wraps 0 -> POOL_SIZE-1
		emits_sent++;
	endtask

	task automatic apply_tick(logic [15:0] step);
		longint spin;
		spin = (longint'(step) * 655) >> 16;
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (live[i]) begin
				if (life_left[i] <= 0) begin
					live[i] = 1'b0;
					retired_seen++;
				end else begin
					life_left[i] = clamp32(longint'(life_left[i]) - longint'(step));
					px[i] = clamp32(longint'(px[i]) +
						((longint'(vx[i]) * longint'(step)) >>> 16));
					py[i] = clamp32(longint'(py[i]) +
						((longint'(vy[i]) * longint'(step)) >>> 16));
					spin_acc[i] = spin_acc[i] + spin[31:0];
				end
			end
		end
		ticks_sent++;
	endtask

	function automatic render_t predict_render(logic [9:0] s);
		render_t r;
		longint f, span, ch_b, ch_e, ch;
		r = '{default: '0};
		if (s >= POOL_SIZE || !live[s]) begin
			return r;
		end
		// life fraction, clamped to 0..1
		if (life_left[s] <= 0) begin
			f = 0;
		end else if (life_left[s] >= life_all[s]) begin
			f = 65536;
		end else begin
			f = (longint'(life_left[s]) * 65536) / longint'(life_all[s]);
		end
		span = longint'(sz_b[s]) - longint'(sz_e[s]);
		r.alive     = 1'b1;
		r.pos_x     = px[s];
		r.pos_y     = py[s];
		r.angle     = spin_acc[s];
		r.quad_size = clamp32(longint'(sz_e[s]) + ((span * f) >>> 16));
		for (int sh = 0; sh < 32; sh += 8) begin
			ch_b = longint'(col_b[s][sh +: 8]);
			ch_e = longint'(col_e[s][sh +: 8]);
			ch   = ch_e + (((ch_b - ch_e) * f) >>> 16);
			r.color[sh +: 8] = ch[7:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// sender: one word on the slave side, prediction on acceptance
	// ---------------------------------------------------------------
	task automatic send_word(action_t act, logic [31:0] ox, logic [31:0] oy,
			logic [31:0] bvx, logic [31:0] bvy, logic [15:0] step, logic [9:0] s,
			logic [15:0] ra, logic [15:0] rvx, logic [15:0] rvy, logic [15:0] rsz);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = {6'd0, rsz, rvy, rvx, ra, s, step, bvy, bvx, oy, ox};
		do begin
			@(posedge clk);
		end while (!s_tready);
		words_sent++;
		case (act)
			ACT_EMIT: begin
				apply_emit(ox, oy, bvx, bvy, ra, rvx, rvy, rsz);
			end
			ACT_TICK: begin
				apply_tick(step);
			end
			ACT_RENDER: begin
				pending_renders.push_back(predict_render(s));
			end
			default: begin
				// unused action code: ignored by the block
			end
		endcase
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_emit(logic [31:0] ox, logic [31:0] oy, logic [31:0] bvx,
			logic [31:0] bvy, logic [15:0] ra, logic [15:0] rvx, logic [15:0] rvy,
			logic [15:0] rsz);
		send_word(ACT_EMIT, ox, oy, bvx, bvy, 16'($urandom), 10'($urandom),
			ra, rvx, rvy, rsz);
	endtask

	task automatic send_tick(logic [15:0] step);
		send_word(ACT_TICK, $urandom, $urandom, $urandom, $urandom, step, 10'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic send_render(logic [9:0] s);
		send_word(ACT_RENDER, $urandom, $urandom, $urandom, $urandom, 16'($urandom), s,
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// ---------------------------------------------------------------
	// config writes, only once the block has drained
	// ---------------------------------------------------------------
	task automatic drain();
		while (pending_renders.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_we   = 1'b1;
		cfg_addr = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we   = 1'b0;
		case (idx)
			REG_COLOR_BEGIN: emit_color_b  = val;
			REG_COLOR_END:   emit_color_e  = val;
			REG_SIZE_BEGIN:  emit_size_b   = val[30:0];
			REG_SIZE_END:    emit_size_e   = val[30:0];
			REG_SIZE_VAR:    emit_size_var = val[30:0];
			REG_VEL_VAR_X:   emit_vvar_x   = val[30:0];
			REG_VEL_VAR_Y:   emit_vvar_y   = val[30:0];
			default:         emit_life     = val[30:0];
		endcase
	endtask

	task automatic load_settings(logic [31:0] cb, logic [31:0] ce, logic [31:0] sb,
			logic [31:0] se, logic [31:0] sv, logic [31:0] vvx, logic [31:0] vvy,
			logic [31:0] lt);
		drain();
		write_reg(REG_COLOR_BEGIN, cb);
		write_reg(REG_COLOR_END, ce);
		write_reg(REG_SIZE_BEGIN, sb);
		write_reg(REG_SIZE_END, se);
		write_reg(REG_SIZE_VAR, sv);
		write_reg(REG_VEL_VAR_X, vvx);
		write_reg(REG_VEL_VAR_Y, vvy);
		write_reg(REG_LIFE_TIME, lt);
	endtask

	// ---------------------------------------------------------------
	// result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		render_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.alive     = m_tuser[0];
			got.pos_x     = m_tdata[31:0];
			got.pos_y     = m_tdata[63:32];
			got.angle     = m_tdata[95:64];
			got.quad_size = m_tdata[127:96];
			got.color     = m_tdata[159:128];
			if (pending_renders.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: render word with nothing expected: alive %0b data %h",
						got.alive, m_tdata);
				end
			end else begin
				want = pending_renders.pop_front();
				renders_checked++;
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: render mismatch");
						$display("  expected alive %0b pos %h %h angle %h size %h color %h",
							want.alive, want.pos_x, want.pos_y, want.angle,
							want.quad_size, want.color);
						$display("  actual   alive %0b pos %h %h angle %h size %h color %h",
							got.alive, got.pos_x, got.pos_y, got.angle,
							got.quad_size, got.color);
					end
				end
			end
		end
	end

	// watchdog: counts cycles in which neither side moves a word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: watchdog expired, %0d renders still pending",
					pending_renders.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// extremes with reset settings, the ignored action, an empty slot
	task automatic test_directed_defaults();
		send_render(10'd0);
		send_render(10'd1023);
		send_emit(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		send_emit(32'h80000000, 32'h7FFFFFFF, 32'h00010000, 32'hFFFF0000,
			16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_word(ACT_NONE, '1, '1, '1, '1, '1, 10'd1023, '1, '1, '1, '1);
		send_render(10'd1023);
		send_render(10'd1022);
		send_tick(16'h0000);
		send_tick(16'hFFFF);
		send_render(10'd1023);
		send_render(10'd1022);
	endtask

	// widest settings: velocity and size spread saturate, long life
	task automatic test_directed_saturation();
		load_settings(32'h00FF00FF, 32'hFF00FF00, 32'h7FFFFFFF, 32'h00000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_emit(32'h7FFF0000, 32'h80010000, 32'h7FFFFFFF, 32'h80000000,
			16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_emit(32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF,
			16'h1234, 16'h0000, 16'hFFFF, 16'h0000);
		send_tick(16'hFFFF);
		send_tick(16'h8000);
		send_render(emit_ptr + 10'd1);
		send_render(emit_ptr + 10'd2);
	endtask

	// shortest life: fraction drops to zero and the particle retires
	task automatic test_directed_short_life();
		load_settings(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'h7FFFFFFF,
			32'h00000000, 32'h00000000, 32'h00000000, 32'h00000001);
		send_emit(32'h00010000, 32'h00020000, 32'h00008000, 32'hFFFF8000,
			16'h0001, 16'h8000, 16'h8000, 16'h8000);
		send_render(emit_ptr + 10'd1);
		send_tick(16'h0001);
		send_render(emit_ptr + 10'd1);
		send_tick(16'h0001);
		send_render(emit_ptr + 10'd1);
	endtask

	// random traffic, mostly emits and renders of recent slots, a few ticks
	task automatic test_random_traffic(int n_words);
		int pick;
		logic [31:0] life_pick;
		life_pick = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h30000, 1);
		if (life_pick[30:0] == 0) begin
			life_pick = 32'h1;
		end
		load_settings($urandom, $urandom, $urandom, $urandom,
			($urandom_range(1)) ? $urandom : $urandom_range(32'h40000),
			($urandom_range(1)) ? $urandom : $urandom_range(32'h100000),
			($urandom_range(1)) ? $urandom : $urandom_range(32'h100000),
			life_pick);
		for (int i = 0; i < n_words; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_emit($urandom, $urandom, $urandom, $urandom, 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
			end else if (pick < 85) begin
				if ($urandom_range(9) < 8) begin
					send_render(emit_ptr + 10'd1 + 10'($urandom_range(40)));
				end else begin
					send_render(10'($urandom));
				end
			end else if (pick < 97) begin
				send_tick(($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4096)));
			end else begin
				send_word(ACT_NONE, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
					10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_EMIT;
		m_tready = 1'b0;
		cfg_we   = 1'b0;
		cfg_addr = REG_COLOR_BEGIN;
		cfg_data = '0;
		mismatches      = 0;
		words_sent      = 0;
		renders_checked = 0;
		ticks_sent      = 0;
		emits_sent      = 0;
		retired_seen    = 0;
		idle_cycles     = 0;
		send_idle_pct   = 36;
		recv_idle_pct   = 82;
		emit_ptr        = LAST_SLOT;
		emit_color_b    = 32'hFFFFFFFF;
		emit_color_e    = 32'h0;
		emit_size_b     = 31'd65536;
		emit_size_e     = 31'd0;
		emit_size_var   = 31'd0;
		emit_vvar_x     = 31'd0;
		emit_vvar_y     = 31'd0;
		emit_life       = 31'd65536;
		for (int i = 0; i < POOL_SIZE; i++) begin
			live[i] = 1'b0;
			px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
			spin_acc[i] = '0;
			life_left[i] = 0; life_all[i] = 0;
			sz_b[i] = 0; sz_e[i] = 0;
			col_b[i] = '0; col_e[i] = '0;
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// sender sparse-ish, receiver mostly stalled
		test_directed_defaults();
		test_directed_saturation();
		test_directed_short_life();
		test_random_traffic(260);

		// roles swapped
		send_idle_pct = 82;
		recv_idle_pct = 36;
		test_random_traffic(260);

		// full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(260);

		drain();
		$display("Covered %0d words: %0d emits, %0d ticks, %0d renders checked,",
			words_sent, emits_sent, ticks_sent, renders_checked);
		$display("  %0d particles retired, three idle patterns, five register sets.",
			retired_seen);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/ppe_pkg.sv
hdl/ppe_ram.sv
hdl/ppe_div.sv
hdl/particle_pool_engine.sv
sim/particle_pool_engine_tb.sv
